### rtl/uad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uad_pkg
// shared codes, queue status type and digit encoding for the digit converter
// ----------------------------------------------------------------------------
package uad_pkg;

  // format codes carried on op
  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  // digit slots
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int HEX_BITS   = 32;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_UPPER = 7'h41;
  localparam logic [3:0] DIGIT_TEN   = 4'hA;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } uad_qstat_t;

  // one digit nibble to ascii
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < DIGIT_TEN) begin
      c = ASCII_ZERO + 7'(d);
    end else begin
      c = ASCII_UPPER + 7'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/uad_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uad_queue
// two-entry request queue between front end and conversion engine
// ----------------------------------------------------------------------------
module uad_queue #(
  parameter int W = 33
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [W-1:0]  din,
  input  wire logic          pop,
  output logic [W-1:0]       dout,
  output uad_pkg::uad_qstat_t stat
);
  import uad_pkg::*;

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  assign dout       = mem[rp];
  assign stat.full  = (cnt == 2'd2);
  assign stat.empty = (cnt == 2'd0);

endmodule
`default_nettype wire

### rtl/uad_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uad_front
// accepts requests, masks the value and packs format and value for the queue
// ----------------------------------------------------------------------------
module uad_front #(
  parameter int VW = 32
) (
  input  wire logic                start,
  input  wire logic                op,
  input  wire logic [31:0]         value,
  input  wire uad_pkg::uad_qstat_t qstat,
  output logic                     busy,
  output logic                     push,
  output logic [VW:0]              entry
);
  import uad_pkg::*;

  logic hex;

  assign hex   = (op == OP_HEX);
  assign busy  = qstat.full;
  assign push  = start & ~qstat.full;
  assign entry = {hex, value[VW-1:0]};

endmodule
`default_nettype wire

### rtl/uad_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uad_back
// conversion engine: shift-add-3 for decimal, direct nibbles for hex,
// then one digit per cycle with leading zeros dropped
// ----------------------------------------------------------------------------
module uad_back #(
  parameter int VW = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire uad_pkg::uad_qstat_t qstat,
  input  wire logic [VW:0]         entry,
  output logic                     pop,
  output logic                     strobe,
  output logic [6:0]               ascii_char,
  output logic                     last
);
  import uad_pkg::*;

  localparam int DB = DEC_DIGITS * 4;
  localparam int IW = $clog2(VW + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state;
  logic [VW-1:0] bin;
  logic [DB-1:0] digs;
  logic [DB-1:0] adj;
  logic [IW-1:0] iter;
  logic [3:0]    cnt;
  logic          started;
  logic [3:0]    top;
  logic [HEX_BITS-1:0] hv;

  assign pop = (state == ST_IDLE) & ~qstat.empty;
  assign top = digs[DB-1 -: 4];
  assign hv  = HEX_BITS'(entry[VW-1:0]);

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[i*4 +: 4] = (digs[i*4 +: 4] >= 4'd5) ? digs[i*4 +: 4] + 4'd3 : digs[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      strobe  <= 1'b0;
      started <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            started <= 1'b0;
            if (entry[VW] == OP_HEX) begin
              digs  <= {hv, {(DB - HEX_BITS){1'b0}}};
              cnt   <= 4'(HEX_DIGITS);
              state <= ST_EMIT;
            end else begin
              digs  <= '0;
              bin   <= entry[VW-1:0];
              iter  <= IW'(VW);
              state <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          digs <= {adj[DB-2:0], bin[VW-1]};
          bin  <= bin << 1;
          iter <= iter - IW'(1);
          if (iter == IW'(1)) begin
            cnt   <= 4'(DEC_DIGITS);
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          digs <= digs << 4;
          cnt  <= cnt - 4'd1;
          // leading zero: drop it without a strobe
          if (started || top != 4'd0 || cnt == 4'd1) begin
            started    <= 1'b1;
            strobe     <= 1'b1;
            ascii_char <= digit_char(top);
            last       <= (cnt == 4'd1);
          end
          if (cnt == 4'd1) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/unsigned_to_ascii_digits.sv
`default_nettype none
// decimal runs the shift-add-3 loop before the digit scan, hex goes straight to the digit scan;
//   digits come one per cycle once the first is out
// requests are converted one at a time, paced by the shift-add-3 loop
//   and the digit scan of the single conversion engine; a two-entry queue takes requests ahead
// busy is high only while the queue is full; results are never stalled by the receiver
// reset (rst, synchronous) empties the queue and returns the engine to idle
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// converts an unsigned value to ascii decimal or upper-case hex digits,
// most significant first, no leading zeros, last flag on the final digit
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request side
  input  wire logic        start,
  output logic             busy,
  input  wire logic        op,
  input  wire logic [31:0] value,
  // result side, one digit per strobe
  output logic             strobe,
  output logic [6:0]       ascii_char,
  output logic             last
);
  import uad_pkg::*;

  // only the low bits of value that fit the field take part
  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  uad_qstat_t   qstat;
  logic         push;
  logic         pop;
  logic [VW:0]  entry_in;
  logic [VW:0]  entry_out;

  // front end: accept and classify the request
  uad_front #(.VW(VW)) u_front (
    .start (start),
    .op    (op),
    .value (value),
    .qstat (qstat),
    .busy  (busy),
    .push  (push),
    .entry (entry_in)
  );

  // short queue decoupling acceptance from conversion
  uad_queue #(.W(VW + 1)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (entry_in),
    .pop  (pop),
    .dout (entry_out),
    .stat (qstat)
  );

  // back end: bcd conversion and digit emission
  uad_back #(.VW(VW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .entry      (entry_out),
    .pop        (pop),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .last       (last)
  );

endmodule
`default_nettype wire

### rtl/uad_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uad_checker
// port-level checks on the digit converter, bound to the top level
// ----------------------------------------------------------------------------
module uad_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [6:0] ascii_char,
  input wire logic       last
);

  // every digit is 0-9 or A-F
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((ascii_char >= 7'h30 && ascii_char <= 7'h39) ||
                (ascii_char >= 7'h41 && ascii_char <= 7'h46)))
    else $error("digit out of range");

  // nothing comes out the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe && !busy)
    else $error("activity right after reset");

  // a final digit ends the run: the engine returns to idle before it can restart, so no digit follows it directly
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("digit right after final digit");

  // busy only rises after a request was taken
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without request");

endmodule

bind unsigned_to_ascii_digits uad_checker u_uad_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .ascii_char (ascii_char),
  .last       (last)
);
`default_nettype wire
